### src/sst_pkg.sv
package sst_pkg;

  localparam int SLOTS_DEFAULT = 16;

  localparam int VAL_W   = 32;
  localparam int TIME_W  = 32;
  localparam int ALPHA_W = 17;
  localparam int PROD_W  = 51;

  localparam logic [ALPHA_W-1:0] ALPHA_ONE     = 17'd65536;
  localparam logic [ALPHA_W-1:0] ALPHA_RESET   = 17'd13107;
  localparam logic [TIME_W-1:0]  TIMEOUT_RESET = 32'd1000;

  localparam logic CFG_EMA_ALPHA       = 1'b0;
  localparam logic CFG_DEFAULT_TIMEOUT = 1'b1;

  typedef enum logic [2:0] {
    REQ_UPDATE      = 3'd0,
    REQ_SET         = 3'd1,
    REQ_READ        = 3'd2,
    REQ_SET_TIMEOUT = 3'd3,
    REQ_CHECK       = 3'd4,
    REQ_CLEAR       = 3'd5
  } req_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_EXEC,
    ST_BLEND,
    ST_SWEEP,
    ST_DRAIN,
    ST_RESP
  } state_e;

  typedef enum logic {
    ALU_AGE,
    ALU_BLEND
  } alu_op_e;

endpackage

### src/sst_ram.sv
module sst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### src/sst_alu.sv
module sst_alu (
  input  logic                                   clk_i,
  input  sst_pkg::alu_op_e                       op_i,
  input  logic        [sst_pkg::VAL_W-1:0]       a_i,
  input  logic        [sst_pkg::VAL_W-1:0]       b_i,
  input  logic        [sst_pkg::TIME_W-1:0]      lim_i,
  input  logic        [sst_pkg::ALPHA_W-1:0]     alpha_i,
  output logic                                   expired_o,
  output logic signed [sst_pkg::PROD_W-1:0]      prod_o
);

  logic                                ext;
  logic        [sst_pkg::VAL_W:0]      diff;
  logic signed [sst_pkg::PROD_W-1:0]   prod_d;
  logic signed [sst_pkg::PROD_W-1:0]   prod_q;

  // shared subtractor: wrapping age, or signed sample - old
  always_comb begin
    ext       = (op_i == sst_pkg::ALU_BLEND);
    diff      = {ext & a_i[sst_pkg::VAL_W-1], a_i} - {ext & b_i[sst_pkg::VAL_W-1], b_i};
    expired_o = diff[sst_pkg::VAL_W-1:0] > lim_i;
    prod_d    = sst_pkg::PROD_W'($signed(diff) * $signed({1'b0, alpha_i}));
  end

  always_ff @(posedge clk_i) begin
    if (op_i == sst_pkg::ALU_BLEND) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

### src/smoothed_signal_table_with_timeouts.sv
// Smoothed signal table: SLOTS slots of signed Q16.16 values with EMA smoothing,
// per-slot timeouts and valid flags.
// Input channel (in_valid_i / in_stall_o) carries one request word; the output
// channel (out_valid_o / out_stall_i) returns exactly one result word per request.
// Config port (cfg_we_i, cfg_idx_i, cfg_wdata_i): 0 ema_alpha, 1 default timeout;
// write only while no request is in flight.
// Requests are handled one at a time by a small sequencer around one shared
// subtract/compare/multiply unit; in_stall_o is high while a request is at work.
// Sequence from accept to result valid: FETCH, EXEC, RESP for most requests; update
// of a valid slot adds BLEND after EXEC, check_timeouts while any slot is valid adds
// SWEEP and DRAIN (the sweep reads one slot per cycle from the time and timeout RAMs).
// A new request is accepted only after the previous one has left RESP for IDLE.
// A finished result sits in the output register; the next request is accepted
// meanwhile, and only its completion waits while out_stall_i is high.
// Reset: all slots invalid, timeouts 1000, alpha 13107, no clearing pass needed.
module smoothed_signal_table_with_timeouts #(
  parameter int SLOTS = sst_pkg::SLOTS_DEFAULT
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [31:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         req_type_i,
  input  logic [7:0]         slot_id_i,
  input  logic signed [31:0] sample_value_i,
  input  logic signed [31:0] default_value_i,
  input  logic [31:0]        timeout_value_i,
  input  logic [31:0]        now_ms_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] read_value_o,
  output logic               slot_valid_o,
  output logic               any_valid_o,
  output logic               id_ok_o
);

  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int VW = sst_pkg::VAL_W;
  localparam int PW = sst_pkg::PROD_W;

  sst_pkg::state_e state_q, state_d;

  logic [sst_pkg::ALPHA_W-1:0] alpha_q, alpha_eff;
  logic [31:0]                 dto_q;
  logic [31:0]                 fill_q, fill_d;
  logic [SLOTS-1:0]            valid_q, valid_d;
  logic [SLOTS-1:0]            tset_q, tset_d;
  logic                        any_q, any_d;
  logic                        still_q, still_d;
  logic [AW-1:0]               cnt_q, cnt_d;
  logic [AW-1:0]               chk_idx_q;
  logic                        chk_vld_q;

  sst_pkg::req_e req_q;
  logic [7:0]    id_q;
  logic [31:0]   sample_q, dflt_q, tmo_q, now_q;
  logic [AW-1:0] idx;
  logic          in_range;

  logic          out_vld_q, out_vld_d;
  logic [31:0]   rv_q, rv_d;
  logic          sv_q, sv_d, av_q, av_d, ok_q, ok_d;

  logic          val_we, time_we, tmo_we;
  logic [VW-1:0] val_wdata;
  logic [AW-1:0] raddr;
  logic [VW-1:0] val_rd, time_rd, tmo_rd;

  sst_pkg::alu_op_e     alu_op;
  logic [VW-1:0]        alu_a, alu_b, alu_lim;
  logic                 expired;
  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] sum;
  logic signed [PW-1:0] quo;

  logic accept;

  assign accept    = in_valid_i && (state_q == sst_pkg::ST_IDLE);
  assign idx       = id_q[AW-1:0];
  assign in_range  = {1'b0, id_q} < 9'(SLOTS);
  assign alpha_eff = (alpha_q > sst_pkg::ALPHA_ONE) ? sst_pkg::ALPHA_ONE : alpha_q;
  assign raddr     = (state_q == sst_pkg::ST_SWEEP) ? cnt_q : idx;

  sst_ram #(.WIDTH(VW), .DEPTH(SLOTS)) u_val_ram (
    .clk_i   (clk_i),
    .we_i    (val_we),
    .waddr_i (idx),
    .wdata_i (val_wdata),
    .raddr_i (raddr),
    .rdata_o (val_rd)
  );

  sst_ram #(.WIDTH(VW), .DEPTH(SLOTS)) u_time_ram (
    .clk_i   (clk_i),
    .we_i    (time_we),
    .waddr_i (idx),
    .wdata_i (now_q),
    .raddr_i (raddr),
    .rdata_o (time_rd)
  );

  sst_ram #(.WIDTH(VW), .DEPTH(SLOTS)) u_tmo_ram (
    .clk_i   (clk_i),
    .we_i    (tmo_we),
    .waddr_i (idx),
    .wdata_i (tmo_q),
    .raddr_i (raddr),
    .rdata_o (tmo_rd)
  );

  sst_alu u_alu (
    .clk_i     (clk_i),
    .op_i      (alu_op),
    .a_i       (alu_a),
    .b_i       (alu_b),
    .lim_i     (alu_lim),
    .alpha_i   (alpha_eff),
    .expired_o (expired),
    .prod_o    (prod)
  );

  // old*2^16 + alpha*(sample-old), then divide by 2^16 toward zero
  always_comb begin
    sum = ($signed({{(PW-VW){val_rd[VW-1]}}, val_rd}) <<< 16) + prod;
    quo = sum >>> 16;
    if (sum[PW-1] && (sum[15:0] != 16'd0)) begin
      quo = quo + PW'(1);
    end
  end

  always_comb begin
    state_d   = state_q;
    fill_d    = fill_q;
    valid_d   = valid_q;
    tset_d    = tset_q;
    any_d     = any_q;
    still_d   = still_q;
    cnt_d     = cnt_q;
    val_we    = 1'b0;
    time_we   = 1'b0;
    tmo_we    = 1'b0;
    val_wdata = sample_q;
    alu_op    = sst_pkg::ALU_AGE;
    alu_a     = now_q;
    alu_b     = time_rd;
    alu_lim   = tset_q[chk_idx_q] ? tmo_rd : fill_q;
    out_vld_d = out_vld_q && out_stall_i;
    rv_d      = rv_q;
    sv_d      = sv_q;
    av_d      = av_q;
    ok_d      = ok_q;

    if (chk_vld_q && valid_q[chk_idx_q]) begin
      if (expired) begin
        valid_d[chk_idx_q] = 1'b0;
      end else begin
        still_d = 1'b1;
      end
    end

    unique case (state_q)
      sst_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = sst_pkg::ST_FETCH;
        end
      end
      sst_pkg::ST_FETCH: begin
        state_d = sst_pkg::ST_EXEC;
      end
      sst_pkg::ST_EXEC: begin
        state_d = sst_pkg::ST_RESP;
        case (req_q) inside
          sst_pkg::REQ_UPDATE, sst_pkg::REQ_SET: begin
            if (in_range) begin
              if (req_q == sst_pkg::REQ_UPDATE && valid_q[idx]) begin
                alu_op  = sst_pkg::ALU_BLEND;
                alu_a   = sample_q;
                alu_b   = val_rd;
                state_d = sst_pkg::ST_BLEND;
              end else begin
                val_we       = 1'b1;
                time_we      = 1'b1;
                valid_d[idx] = 1'b1;
                any_d        = 1'b1;
              end
            end
          end
          sst_pkg::REQ_SET_TIMEOUT: begin
            if (in_range) begin
              tmo_we      = 1'b1;
              tset_d[idx] = 1'b1;
            end
          end
          sst_pkg::REQ_CHECK: begin
            if (any_q) begin
              cnt_d   = '0;
              still_d = 1'b0;
              state_d = sst_pkg::ST_SWEEP;
            end
          end
          sst_pkg::REQ_CLEAR: begin
            valid_d = '0;
            tset_d  = '0;
            fill_d  = dto_q;
            any_d   = 1'b0;
          end
          default: begin
          end
        endcase
      end
      sst_pkg::ST_BLEND: begin
        val_we       = 1'b1;
        val_wdata    = quo[VW-1:0];
        time_we      = 1'b1;
        valid_d[idx] = 1'b1;
        any_d        = 1'b1;
        state_d      = sst_pkg::ST_RESP;
      end
      sst_pkg::ST_SWEEP: begin
        cnt_d = cnt_q + AW'(1);
        if (cnt_q == AW'(SLOTS - 1)) begin
          state_d = sst_pkg::ST_DRAIN;
        end
      end
      sst_pkg::ST_DRAIN: begin
        any_d   = still_d;
        state_d = sst_pkg::ST_RESP;
      end
      sst_pkg::ST_RESP: begin
        if (!out_vld_q || !out_stall_i) begin
          out_vld_d = 1'b1;
          av_d      = any_q;
          rv_d      = '0;
          sv_d      = 1'b0;
          ok_d      = 1'b0;
          case (req_q) inside
            sst_pkg::REQ_UPDATE, sst_pkg::REQ_SET, sst_pkg::REQ_SET_TIMEOUT: begin
              ok_d = in_range;
              sv_d = in_range && valid_q[idx];
            end
            sst_pkg::REQ_READ: begin
              ok_d = in_range;
              sv_d = in_range && valid_q[idx];
              rv_d = (in_range && valid_q[idx]) ? val_rd : dflt_q;
            end
            sst_pkg::REQ_CHECK, sst_pkg::REQ_CLEAR: begin
              ok_d = 1'b1;
            end
            default: begin
            end
          endcase
          state_d = sst_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = sst_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= sst_pkg::ST_IDLE;
      alpha_q   <= sst_pkg::ALPHA_RESET;
      dto_q     <= sst_pkg::TIMEOUT_RESET;
      fill_q    <= sst_pkg::TIMEOUT_RESET;
      valid_q   <= '0;
      tset_q    <= '0;
      any_q     <= 1'b0;
      still_q   <= 1'b0;
      cnt_q     <= '0;
      chk_idx_q <= '0;
      chk_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      fill_q    <= fill_d;
      valid_q   <= valid_d;
      tset_q    <= tset_d;
      any_q     <= any_d;
      still_q   <= still_d;
      cnt_q     <= cnt_d;
      chk_idx_q <= cnt_q;
      chk_vld_q <= (state_q == sst_pkg::ST_SWEEP);
      out_vld_q <= out_vld_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          sst_pkg::CFG_EMA_ALPHA:       alpha_q <= cfg_wdata_i[sst_pkg::ALPHA_W-1:0];
          sst_pkg::CFG_DEFAULT_TIMEOUT: dto_q   <= cfg_wdata_i;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q    <= sst_pkg::req_e'(req_type_i);
      id_q     <= slot_id_i;
      sample_q <= sample_value_i;
      dflt_q   <= default_value_i;
      tmo_q    <= timeout_value_i;
      now_q    <= now_ms_i;
    end
    rv_q <= rv_d;
    sv_q <= sv_d;
    av_q <= av_d;
    ok_q <= ok_d;
  end

  assign in_stall_o   = (state_q != sst_pkg::ST_IDLE);
  assign out_valid_o  = out_vld_q;
  assign read_value_o = rv_q;
  assign slot_valid_o = sv_q;
  assign any_valid_o  = av_q;
  assign id_ok_o      = ok_q;

  a_any_covers_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !any_q |-> (valid_q == '0))
    else $error("valid slot while summary flag clear");

  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sst_pkg::ST_IDLE || state_q == sst_pkg::ST_RESP ||
     state_q == sst_pkg::ST_FETCH) |=> (valid_q == $past(valid_q)))
    else $error("valid flags changed outside an executing step");

  a_sweep_no_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sst_pkg::ST_SWEEP || state_q == sst_pkg::ST_DRAIN) |=>
    ((valid_q & ~$past(valid_q)) == '0))
    else $error("sweep raised a valid flag");

endmodule
